/* rtl/core/pressure_event_detector_unit_assert.svh */
// Assertion macros shared by the pressure event detector modules
`ifndef PRESSURE_EVENT_DETECTOR_UNIT_ASSERT_SVH
`define PRESSURE_EVENT_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PED_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pressure event detector check failed");

// next-cycle implication, checked outside reset
`define PED_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pressure event detector check failed");

`endif

/* rtl/core/ped_pkg.sv */
// Types and constants of the pressure event detector
package ped_pkg;

   // input word
   typedef struct packed {
      logic [22:0] pressure;
      logic [31:0] time_ms;
   } req_type;

   // result word
   typedef struct packed {
      logic               event_active;
      logic signed [31:0] filtered_slope;
      logic [30:0]        threshold;
   } rsp_type;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLOPE,
      ST_FILT,
      ST_THR,
      ST_THR2,
      ST_NORM_LO,
      ST_NORM_SUM,
      ST_MEAN_GO,
      ST_MEAN_W,
      ST_DEV_GO,
      ST_DEV_W,
      ST_EVENT,
      ST_WRITE
   } state_type;

   // register indexes
   localparam logic [1:0] CSR_MULT  = 2'd0;
   localparam logic [1:0] CSR_HOLD  = 2'd1;
   localparam logic [1:0] CSR_DECAY = 2'd2;

   // register reset values
   localparam logic [15:0] MULT_RST  = 16'd1536;
   localparam logic [15:0] HOLD_RST  = 16'd1500;
   localparam logic [24:0] DECAY_RST = 25'd16775538;

   // filter coefficients, Q2.16, signs folded in
   localparam logic signed [25:0] COEF_B0  = 26'sd4421;
   localparam logic signed [25:0] COEF_B1  = 26'sd8841;
   localparam logic signed [25:0] COEF_B2  = 26'sd4421;
   localparam logic signed [25:0] COEF_NA1 = 26'sd74906;
   localparam logic signed [25:0] COEF_NA2 = -26'sd27053;

   // shared multiplier operand widths
   localparam int MUL_AW = 33;
   localparam int MUL_BW = 26;
   localparam int MUL_PW = MUL_AW + MUL_BW;

endpackage

/* rtl/core/ped_mul.sv */
// Shared signed multiplier with registered product
module ped_mul (
   input  logic                                   clock,
   input  logic signed [ped_pkg::MUL_AW-1:0]      mul_a,
   input  logic signed [ped_pkg::MUL_BW-1:0]      mul_b,
   output logic signed [ped_pkg::MUL_PW-1:0]      mul_p
);

   logic signed [ped_pkg::MUL_PW-1:0] prod_ff;
   logic signed [ped_pkg::MUL_PW-1:0] prod_in;

   // one product per cycle
   always_comb begin
      prod_in = ped_pkg::MUL_PW'(mul_a) * ped_pkg::MUL_PW'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

/* rtl/core/ped_div.sv */
// Shared unsigned restoring divider, one quotient bit per cycle
`include "pressure_event_detector_unit_assert.svh"
module ped_div #(
   parameter int DW = 50,
   parameter int DV = 43
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DW-1:0]           dividend,
   input  logic [DV-1:0]           divisor,
   output logic [DW-1:0]           quotient,
   output ped_pkg::div_status_type status
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [DV-1:0] rem_ff, rem_in;
   logic [DV-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DV:0]   trial;

   // shift-subtract step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DV'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = DV'(trial);
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `PED_ASSERT_IMPL(a_no_restart, start, !busy_ff)
   `PED_ASSERT_NEXT(a_start_busy, start, busy_ff)
   `PED_ASSERT_IMPL(a_done_idle, done_ff, !busy_ff)

endmodule

/* rtl/core/pressure_event_detector_unit.sv */
// Pressure event detector: sequencer around a shared multiplier and divider.
// The first sample after reset only primes the detector and goes straight to the output word; later samples
// wait on three bit-serial divisions (slope, mean step, deviation step) on one divider, the slope
// division being skipped when no time has passed, and skip the norm update states when the norm holds.
// The next sample is accepted from the cycle after the word loads, not before; a stalled word holds it.
// Reset (synchronous, active high) restores registers and detector state.
`include "pressure_event_detector_unit_assert.svh"
module pressure_event_detector_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ped_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ped_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [24:0]      csr_data
);

   localparam int DW = 34 + FRAC_BITS;
   localparam int DV = 43;
   localparam logic [39:0] NORM_ONE = 40'd1 << FRAC_BITS;
   localparam logic [31:0] MAD_RST  = 32'd2 << FRAC_BITS;

   ped_pkg::state_type state_ff, state_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               primed_ff, primed_in;
   logic [22:0]        last_p_ff, last_p_in;
   logic [31:0]        last_t_ff, last_t_in;
   logic signed [31:0] sh_ff [0:2];
   logic signed [31:0] sh_in [0:2];
   logic signed [31:0] fh_ff [0:2];
   logic signed [31:0] fh_in [0:2];
   logic [39:0]        norm_ff, norm_in;
   logic signed [31:0] mean_ff, mean_in;
   logic [31:0]        mad_ff, mad_in;
   logic               in_event_ff, in_event_in;
   logic               bp_ff, bp_in;
   logic [31:0]        rt_ff, rt_in;
   logic [15:0]        mult_ff, mult_in;
   logic [15:0]        hold_ff, hold_in;
   logic [24:0]        decay_ff, decay_in;
   logic signed [55:0] acc_ff, acc_in;
   logic [30:0]        thr_ff, thr_in;
   logic               slow_ff, slow_in;
   logic               neg_ff, neg_in;
   logic               zero_ff, zero_in;
   logic [40:0]        phi_ff, phi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ped_pkg::rsp_type   rsp_ff, rsp_in;

   logic signed [ped_pkg::MUL_AW-1:0] mul_a;
   logic signed [ped_pkg::MUL_BW-1:0] mul_b;
   logic signed [ped_pkg::MUL_PW-1:0] mul_p;
   logic                    div_start;
   logic [DW-1:0]           div_dividend;
   logic [DV-1:0]           div_divisor;
   logic [DW-1:0]           div_q;
   ped_pkg::div_status_type div_st;

   // scratch values of the sequencer
   logic signed [23:0] dp;
   logic [22:0]        adp;
   logic [32:0]        dp_k;
   logic [31:0]        dt;
   logic signed [55:0] rnd;
   logic signed [55:0] shr;
   logic [39:0]        thr_raw;
   logic [32:0]        mag;
   logic [41:0]        nsum;
   logic signed [33:0] dd;
   logic [32:0]        dabs;
   logic signed [34:0] d2;
   logic [33:0]        d2abs;
   logic signed [DW+1:0] qs;
   logic signed [DW+1:0] acc2;
   logic               accept;

   ped_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   ped_div #(.DW(DW), .DV(DV)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .status   (div_st)
   );

   // sign and magnitude to saturated 32-bit signed
   function automatic logic signed [31:0] sat_sm(input logic neg, input logic [DW-1:0] q);
      logic signed [31:0] r;
      r = 32'sd0;
      if (neg) begin
         if (q >= DW'(33'h080000000)) r = 32'sh80000000;
         else                         r = -$signed(q[31:0]);
      end else begin
         if (q >= DW'(33'h080000000)) r = 32'sh7FFFFFFF;
         else                         r = $signed(q[31:0]);
      end
      return r;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ped_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer: next state and datapath
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      primed_in    = primed_ff;
      last_p_in    = last_p_ff;
      last_t_in    = last_t_ff;
      sh_in        = sh_ff;
      fh_in        = fh_ff;
      norm_in      = norm_ff;
      mean_in      = mean_ff;
      mad_in       = mad_ff;
      in_event_in  = in_event_ff;
      bp_in        = bp_ff;
      rt_in        = rt_ff;
      mult_in      = mult_ff;
      hold_in      = hold_ff;
      decay_in     = decay_ff;
      acc_in       = acc_ff;
      thr_in       = thr_ff;
      slow_in      = slow_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      phi_in       = phi_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      dp      = $signed({1'b0, req_data.pressure}) - $signed({1'b0, last_p_ff});
      adp     = dp[23] ? 23'(-dp) : dp[22:0];
      dp_k    = {adp, 10'b0} - {6'b0, adp, 4'b0} - {7'b0, adp, 3'b0};
      dt      = req_data.time_ms - last_t_ff;
      rnd     = acc_ff + 56'sd32768;
      shr     = rnd >>> 16;
      thr_raw = mul_p[47:8];
      mag     = fh_ff[0][31] ? 33'(-{fh_ff[0][31], fh_ff[0]}) : {1'b0, fh_ff[0]};
      nsum    = {1'b0, phi_ff} + 42'(mul_p[48:24]) + {2'b0, NORM_ONE};
      dd      = $signed({{2{fh_ff[0][31]}}, fh_ff[0]}) - $signed({{2{mean_ff[31]}}, mean_ff});
      dabs    = dd[33] ? 33'(-dd) : dd[32:0];
      d2      = $signed({2'b0, dabs}) - $signed({3'b0, mad_ff});
      d2abs   = d2[34] ? 34'(-d2) : d2[33:0];
      qs      = neg_ff ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
      acc2    = '0;

      // output register frees when its word is taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            ped_pkg::CSR_MULT:  mult_in  = csr_data[15:0];
            ped_pkg::CSR_HOLD:  hold_in  = csr_data[15:0];
            ped_pkg::CSR_DECAY: decay_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ped_pkg::ST_IDLE: begin
            if (accept) begin
               last_p_in = req_data.pressure;
               last_t_in = req_data.time_ms;
               if (!primed_ff) begin
                  primed_in = 1'b1;
                  thr_in    = '0;
                  state_in  = ped_pkg::ST_WRITE;
               end else begin
                  neg_in       = dp[23];
                  zero_in      = (dt == 32'd0);
                  div_start    = (dt != 32'd0);
                  div_dividend = DW'(dp_k) << FRAC_BITS;
                  div_divisor  = DV'({dt, 6'b0});
                  state_in     = ped_pkg::ST_SLOPE;
               end
            end
         end
         ped_pkg::ST_SLOPE: begin
            if (zero_ff || div_st.done) begin
               sh_in[2] = sh_ff[1];
               sh_in[1] = sh_ff[0];
               sh_in[0] = zero_ff ? 32'sd0 : sat_sm(neg_ff, div_q);
               fh_in[2] = fh_ff[1];
               fh_in[1] = fh_ff[0];
               acc_in   = '0;
               cnt_in   = 3'd0;
               state_in = ped_pkg::ST_FILT;
            end
         end
         ped_pkg::ST_FILT: begin
            // one tap per cycle, product summed in the cycle after
            case (cnt_ff)
               3'd0: begin mul_a = 33'(fh_ff[1]); mul_b = ped_pkg::COEF_NA1; end
               3'd1: begin mul_a = 33'(fh_ff[2]); mul_b = ped_pkg::COEF_NA2; end
               3'd2: begin mul_a = 33'(sh_ff[0]); mul_b = ped_pkg::COEF_B0;  end
               3'd3: begin mul_a = 33'(sh_ff[1]); mul_b = ped_pkg::COEF_B1;  end
               3'd4: begin mul_a = 33'(sh_ff[2]); mul_b = ped_pkg::COEF_B2;  end
               default: ;
            endcase
            if (cnt_ff != 3'd0) acc_in = acc_ff + 56'(mul_p);
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) state_in = ped_pkg::ST_THR;
         end
         ped_pkg::ST_THR: begin
            // round half up, saturate
            if (shr > 56'sh7FFFFFFF)       fh_in[0] = 32'sh7FFFFFFF;
            else if (shr < -56'sh80000000) fh_in[0] = 32'sh80000000;
            else                           fh_in[0] = shr[31:0];
            mul_a    = $signed({1'b0, mad_ff});
            mul_b    = $signed({10'b0, mult_ff});
            state_in = ped_pkg::ST_THR2;
         end
         ped_pkg::ST_THR2: begin
            thr_in  = (thr_raw > 40'h7FFFFFFF) ? 31'h7FFFFFFF : thr_raw[30:0];
            slow_in = !(mag < {2'b0, thr_in});
            if (mag < {2'b0, thr_in}) begin
               mul_a    = $signed(33'(norm_ff[39:24]));
               mul_b    = $signed({1'b0, decay_ff});
               state_in = ped_pkg::ST_NORM_LO;
            end else begin
               state_in = ped_pkg::ST_MEAN_GO;
            end
         end
         ped_pkg::ST_NORM_LO: begin
            phi_in   = mul_p[40:0];
            mul_a    = $signed(33'(norm_ff[23:0]));
            mul_b    = $signed({1'b0, decay_ff});
            state_in = ped_pkg::ST_NORM_SUM;
         end
         ped_pkg::ST_NORM_SUM: begin
            norm_in  = (nsum > 42'hFFFFFFFFFF) ? 40'hFFFFFFFFFF : nsum[39:0];
            state_in = ped_pkg::ST_MEAN_GO;
         end
         ped_pkg::ST_MEAN_GO: begin
            neg_in       = dd[33];
            div_start    = 1'b1;
            div_dividend = DW'(dabs) << FRAC_BITS;
            div_divisor  = slow_ff ? {norm_ff, 3'b0} : DV'(norm_ff);
            state_in     = ped_pkg::ST_MEAN_W;
         end
         ped_pkg::ST_MEAN_W: begin
            if (div_st.done) begin
               acc2 = $signed((DW+2)'(mean_ff)) + qs;
               if (acc2 > (DW+2)'(32'sh7FFFFFFF))       mean_in = 32'sh7FFFFFFF;
               else if (acc2 < -(DW+2)'(33'sh80000000)) mean_in = 32'sh80000000;
               else                                      mean_in = acc2[31:0];
               state_in = ped_pkg::ST_DEV_GO;
            end
         end
         ped_pkg::ST_DEV_GO: begin
            neg_in       = d2[34];
            div_start    = 1'b1;
            div_dividend = DW'(d2abs) << FRAC_BITS;
            div_divisor  = slow_ff ? {norm_ff, 3'b0} : DV'(norm_ff);
            state_in     = ped_pkg::ST_DEV_W;
         end
         ped_pkg::ST_DEV_W: begin
            if (div_st.done) begin
               acc2 = $signed({{(DW-30){1'b0}}, mad_ff}) + qs;
               if (acc2 < 0)                                          mad_in = '0;
               else if (acc2 > $signed({{(DW-30){1'b0}}, 32'hFFFFFFFF})) mad_in = '1;
               else                                                   mad_in = acc2[31:0];
               state_in = ped_pkg::ST_EVENT;
            end
         end
         ped_pkg::ST_EVENT: begin
            // start above threshold, release after hold time below
            if (mag > {2'b0, thr_ff}) begin
               in_event_in = 1'b1;
               bp_in       = 1'b1;
            end else if (in_event_ff) begin
               if (bp_ff) begin
                  rt_in = last_t_ff;
                  bp_in = 1'b0;
               end
               if ((last_t_ff - (bp_ff ? last_t_ff : rt_ff)) > {16'b0, hold_ff})
                  in_event_in = 1'b0;
            end
            state_in = ped_pkg::ST_WRITE;
         end
         ped_pkg::ST_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.event_active   = in_event_ff;
               rsp_in.filtered_slope = fh_ff[0];
               rsp_in.threshold      = thr_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ped_pkg::ST_IDLE;
            end
         end
         default: state_in = ped_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ped_pkg::ST_IDLE;
         cnt_ff       <= '0;
         primed_ff    <= 1'b0;
         last_p_ff    <= '0;
         last_t_ff    <= '0;
         for (int i = 0; i < 3; i++) begin
            sh_ff[i] <= '0;
            fh_ff[i] <= '0;
         end
         norm_ff      <= NORM_ONE;
         mean_ff      <= '0;
         mad_ff       <= MAD_RST;
         in_event_ff  <= 1'b0;
         bp_ff        <= 1'b0;
         rt_ff        <= '0;
         mult_ff      <= ped_pkg::MULT_RST;
         hold_ff      <= ped_pkg::HOLD_RST;
         decay_ff     <= ped_pkg::DECAY_RST;
         thr_ff       <= '0;
         slow_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         primed_ff    <= primed_in;
         last_p_ff    <= last_p_in;
         last_t_ff    <= last_t_in;
         sh_ff        <= sh_in;
         fh_ff        <= fh_in;
         norm_ff      <= norm_in;
         mean_ff      <= mean_in;
         mad_ff       <= mad_in;
         in_event_ff  <= in_event_in;
         bp_ff        <= bp_in;
         rt_ff        <= rt_in;
         mult_ff      <= mult_in;
         hold_ff      <= hold_in;
         decay_ff     <= decay_in;
         thr_ff       <= thr_in;
         slow_ff      <= slow_in;
         neg_ff       <= neg_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff <= acc_in;
      phi_ff <= phi_in;
      rsp_ff <= rsp_in;
   end

   `PED_ASSERT_IMPL(a_div_done_wait, div_st.done, (state_ff == ped_pkg::ST_SLOPE) || (state_ff == ped_pkg::ST_MEAN_W) || (state_ff == ped_pkg::ST_DEV_W))
   `PED_ASSERT_NEXT(a_prime_direct, accept && !primed_ff, state_ff == ped_pkg::ST_WRITE)
   `PED_ASSERT_NEXT(a_write_loads, (state_ff == ped_pkg::ST_WRITE) && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff && (state_ff == ped_pkg::ST_IDLE))

endmodule
